FILE: src/pprr_pkg.sv
`timescale 1ns / 1ps

package pprr_pkg;

  localparam int unsigned NumPos   = 12;
  localparam int unsigned NumPiece = 6;

  // Number of valid codes: 665280 orderings times 64 orientation patterns.
  localparam logic [25:0] CodeLimit = 26'd42577920;

  // Mixed-radix weights of the six digits, digit 0 most significant.
  localparam logic [19:0] Weight [NumPiece] = '{
    20'd55440, 20'd5040, 20'd504, 20'd56, 20'd7, 20'd1
  };

  typedef enum logic {
    CMD_RANK   = 1'b0,
    CMD_UNRANK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  pos_0;
    logic [3:0]  pos_1;
    logic [3:0]  pos_2;
    logic [3:0]  pos_3;
    logic [3:0]  pos_4;
    logic [3:0]  pos_5;
    logic [5:0]  flip_bits;
    logic [25:0] code_in;
  } in_t;

  typedef struct packed {
    logic [25:0] code_out;
    logic [3:0]  pos_out_0;
    logic [3:0]  pos_out_1;
    logic [3:0]  pos_out_2;
    logic [3:0]  pos_out_3;
    logic [3:0]  pos_out_4;
    logic [3:0]  pos_out_5;
    logic [5:0]  flip_out;
    logic        bad_input;
  } out_t;

  // Result of the rank path once it is aligned with the unrank path.
  typedef struct packed {
    logic        bad;
    logic [25:0] code;
  } rank_res_t;

  // Result of the unrank path.
  typedef struct packed {
    logic            bad;
    logic [5:0]      flip;
    logic [5:0][3:0] pos;
  } unrank_res_t;

  // Quotient of r by w for quotients up to 11, by parallel compares against
  // the multiples of w; w is always a constant at the call site.
  function automatic logic [3:0] div_digit(input logic [19:0] r, input logic [19:0] w);
    logic [3:0] cnt;
    cnt = '0;
    for (int k = 1; k < NumPos; k++) begin
      if (r >= 20'(k) * w) begin
        cnt = cnt + 4'd1;
      end
    end
    return cnt;
  endfunction

  // Position of the d-th free slot in the taken mask, counting from zero.
  function automatic logic [3:0] sel_free(input logic [11:0] taken, input logic [3:0] d);
    logic [3:0] res;
    logic [3:0] cnt;
    res = '0;
    for (int k = 0; k < NumPos; k++) begin
      cnt = '0;
      for (int j = 0; j < k; j++) begin
        cnt = cnt + {3'b000, ~taken[j]};
      end
      if (!taken[k] && cnt == d) begin
        res = 4'(k);
      end
    end
    return res;
  endfunction

endpackage

FILE: src/pprr_rank.sv
`timescale 1ns / 1ps

module pprr_rank import pprr_pkg::*; (
  input  logic      clk_i,
  input  in_t       data_i,
  output rank_res_t res_o
);

  typedef struct packed {
    logic            bad;
    logic [5:0]      flip;
    logic [5:0][3:0] dig;
  } dig_t;

  typedef struct packed {
    logic        bad;
    logic [5:0]  flip;
    logic [19:0] sum_a;
    logic [19:0] sum_b;
    logic [19:0] sum_c;
  } part_t;

  localparam int unsigned DelayDepth = 5;

  dig_t            dig_d, dig_q;
  part_t           part_d, part_q;
  rank_res_t       code_d;
  rank_res_t       dly_q [DelayDepth];
  logic [5:0][3:0] p;
  logic [19:0]     total;

  // Digit i is the position minus the number of earlier positions below it.
  always_comb begin
    p = {data_i.pos_5, data_i.pos_4, data_i.pos_3,
         data_i.pos_2, data_i.pos_1, data_i.pos_0};
    dig_d.bad  = 1'b0;
    dig_d.flip = data_i.flip_bits;
    for (int i = 0; i < NumPiece; i++) begin
      dig_d.dig[i] = p[i];
      if (p[i] > 4'd11) begin
        dig_d.bad = 1'b1;
      end
      for (int j = 0; j < i; j++) begin
        if (p[j] == p[i]) begin
          dig_d.bad = 1'b1;
        end
        if (p[j] < p[i]) begin
          dig_d.dig[i] = dig_d.dig[i] - 4'd1;
        end
      end
    end
  end

  always_comb begin
    part_d.bad   = dig_q.bad;
    part_d.flip  = dig_q.flip;
    part_d.sum_a = 20'(dig_q.dig[0]) * Weight[0] + 20'(dig_q.dig[1]) * Weight[1];
    part_d.sum_b = 20'(dig_q.dig[2]) * Weight[2] + 20'(dig_q.dig[3]) * Weight[3];
    part_d.sum_c = 20'(dig_q.dig[4]) * Weight[4] + 20'(dig_q.dig[5]);
  end

  always_comb begin
    total      = part_q.sum_a + part_q.sum_b + part_q.sum_c;
    code_d.bad = part_q.bad;
    if (part_q.bad) begin
      code_d.code = '0;
    end else begin
      code_d.code = {total, part_q.flip};
    end
  end

  // The delay line lines the short rank path up with the unrank path.
  always_ff @(posedge clk_i) begin
    dig_q    <= dig_d;
    part_q   <= part_d;
    dly_q[0] <= code_d;
    for (int s = 1; s < DelayDepth; s++) begin
      dly_q[s] <= dly_q[s-1];
    end
  end

  assign res_o = dly_q[DelayDepth-1];

endmodule

FILE: src/pprr_unrank.sv
`timescale 1ns / 1ps

module pprr_unrank import pprr_pkg::*; (
  input  logic        clk_i,
  input  logic [25:0] code_i,
  output unrank_res_t res_o
);

  typedef struct packed {
    logic            bad;
    logic [5:0]      flip;
    logic [19:0]     rem;
    logic [5:0][3:0] dig;
    logic [5:0][3:0] pos;
    logic [11:0]     taken;
  } stage_t;

  localparam int unsigned NumStage = 7;

  stage_t stg_d [NumStage];
  stage_t stg_q [NumStage];

  // Stage 0 splits off the orientation bits and extracts digit 0. Stages 1 to 4
  // extract one digit each (stage 4 also leaves digit 5 as the remainder).
  // Stages 1 to 6 place one piece each, stage s placing piece s-1.
  always_comb begin
    stg_d[0].bad   = (code_i >= CodeLimit);
    stg_d[0].flip  = code_i[5:0];
    stg_d[0].dig   = '0;
    stg_d[0].pos   = '0;
    stg_d[0].taken = '0;
    stg_d[0].dig[0] = div_digit(code_i[25:6], Weight[0]);
    stg_d[0].rem    = code_i[25:6] - 20'(stg_d[0].dig[0]) * Weight[0];
    for (int s = 1; s < NumStage; s++) begin
      stg_d[s] = stg_q[s-1];
      if (s < NumPiece - 1) begin
        stg_d[s].dig[s] = div_digit(stg_q[s-1].rem, Weight[s]);
        stg_d[s].rem    = stg_q[s-1].rem - 20'(stg_d[s].dig[s]) * Weight[s];
        if (s == NumPiece - 2) begin
          stg_d[s].dig[NumPiece-1] = stg_d[s].rem[3:0];
        end
      end
      stg_d[s].pos[s-1] = sel_free(stg_q[s-1].taken, stg_q[s-1].dig[s-1]);
      stg_d[s].taken    = stg_q[s-1].taken | (12'd1 << stg_d[s].pos[s-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NumStage; s++) begin
      stg_q[s] <= stg_d[s];
    end
  end

  assign res_o.bad  = stg_q[NumStage-1].bad;
  assign res_o.flip = stg_q[NumStage-1].flip;
  assign res_o.pos  = stg_q[NumStage-1].pos;

endmodule

FILE: src/partial_permutation_rank_unrank.sv
`timescale 1ns / 1ps
// A beat accepted with start high shows its result with done_o high once it has
// passed the valid pipeline and the registered output stage.
// Throughput: one beat per cycle; busy stays low, set by the seven-stage
// digit and placement pipeline of the unrank path.
// Reset clears the valid pipeline and the output strobe; beats in flight are
// dropped. The receiver cannot stall, so no result is ever held back.
module partial_permutation_rank_unrank import pprr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  data_i,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned Depth = 7;

  logic              accept;
  logic [Depth-1:0]  vld_d, vld_q;
  logic [Depth-1:0]  cmd_q;
  rank_res_t         rank_res;
  unrank_res_t       unrank_res;
  out_t              res_d, res_q;
  logic              done_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign vld_d  = {vld_q[Depth-2:0], accept};

  pprr_rank u_rank (
    .clk_i  (clk_i),
    .data_i (data_i),
    .res_o  (rank_res)
  );

  pprr_unrank u_unrank (
    .clk_i  (clk_i),
    .code_i (data_i.code_in),
    .res_o  (unrank_res)
  );

  always_comb begin
    res_d = '0;
    if (cmd_q[Depth-1] == CMD_UNRANK) begin
      res_d.bad_input = unrank_res.bad;
      if (!unrank_res.bad) begin
        res_d.pos_out_0 = unrank_res.pos[0];
        res_d.pos_out_1 = unrank_res.pos[1];
        res_d.pos_out_2 = unrank_res.pos[2];
        res_d.pos_out_3 = unrank_res.pos[3];
        res_d.pos_out_4 = unrank_res.pos[4];
        res_d.pos_out_5 = unrank_res.pos[5];
        res_d.flip_out  = unrank_res.flip;
      end
    end else begin
      res_d.bad_input = rank_res.bad;
      res_d.code_out  = rank_res.code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= {cmd_q[Depth-2:0], data_i.cmd};
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##8 done_o)
    else $error("accepted beat produced no result after eight cycles");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.bad_input |->
      result_o.code_out == '0 && result_o.flip_out == '0 &&
      result_o.pos_out_0 == '0 && result_o.pos_out_5 == '0)
    else $error("rejected beat carries nonzero result fields");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.code_out < CodeLimit)
    else $error("rank code beyond the last valid index");

  a_unrank_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.bad_input && result_o.code_out == '0 &&
      result_o.pos_out_0 != result_o.pos_out_1 |->
      result_o.pos_out_0 <= 4'd11 && result_o.pos_out_5 <= 4'd11 &&
      result_o.pos_out_4 != result_o.pos_out_5)
    else $error("unrank produced an out-of-range or repeated position");

endmodule
